/* src/dpsc_pkg.sv */
// Shared constants and types of the distance-paced sine chaser.
package dpsc_pkg;

  localparam int LED_COUNT       = 48;
  localparam int SINE_TABLE_BITS = 8;

  localparam int TIME_BITS   = 32;
  localparam int COUNT_BITS  = 16;
  localparam int DIST_BITS   = 16;
  localparam int CHAN_BITS   = 8;
  localparam int IDX_BITS    = 6;

  localparam int PHASE_SCALE   = 1000;
  localparam int W_BITS        = DIST_BITS + $clog2(PHASE_SCALE);
  localparam int K_BITS        = DIST_BITS + 1;
  localparam int PROD_BITS     = TIME_BITS + K_BITS;
  localparam int LOOP_CNT_BITS = $clog2(PROD_BITS);

  localparam int V_BITS   = $clog2(LED_COUNT + 1);
  localparam int CMP_BITS = W_BITS + V_BITS;

  localparam int STEP_U = (1 << SINE_TABLE_BITS) / LED_COUNT;
  localparam int STEP_V = (1 << SINE_TABLE_BITS) % LED_COUNT;

  localparam int HALF_TURN = 1 << (SINE_TABLE_BITS - 1);
  localparam int AMP_SHIFT = 11;
  localparam int Q_BITS    = 2 * SINE_TABLE_BITS - 3;
  localparam int DEN_BITS  = 2 * SINE_TABLE_BITS + 1;
  localparam int NUM_BITS  = Q_BITS + AMP_SHIFT;
  localparam int QUO_BITS  = 8;
  localparam int MID_LEVEL = 128;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_COLOR_RED         = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COLOR_GREEN       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COLOR_BLUE        = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_DISTANCE_M    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GLOBAL_BRIGHTNESS = 3'd4;

  localparam logic [CHAN_BITS-1:0] RESET_COLOR_RED         = 8'd128;
  localparam logic [CHAN_BITS-1:0] RESET_COLOR_GREEN       = 8'd255;
  localparam logic [CHAN_BITS-1:0] RESET_COLOR_BLUE        = 8'd0;
  localparam logic [DIST_BITS-1:0] RESET_MAX_DISTANCE_M    = 16'd5000;
  localparam logic [CHAN_BITS-1:0] RESET_GLOBAL_BRIGHTNESS = 8'd150;

  typedef struct packed {
    logic [IDX_BITS-1:0] idx;
    logic                last;
    logic                blank;
  } led_tag_t;

endpackage

/* src/distance_paced_sine_chaser.sv */
// Top level of the distance-paced sine chaser: frame front end and per-LED pipeline.

// Each accepted frame beat produces LED_COUNT result beats, one per LED in strip order.
// The frame front end works out the animation phase with a one-bit-per-cycle remainder
// unit: it accepts the beat, multiplies, runs 49 remainder steps, negates the phase, runs
// SINE_TABLE_BITS quotient steps and hands the frame to the LED sequencer. The sequencer
// issues one LED per cycle, unless out_stall holds the output, into a 14-stage pipeline
// whose sine amplitude divider retires one quotient bit per stage, so the next frame is
// taken while the previous one is still being emitted. Configuration is written through
// cfg_valid/cfg_ready, which is always ready, and must only change while no frame is in
// flight.
module distance_paced_sine_chaser (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dpsc_pkg::TIME_BITS-1:0]      time_ms,
  input  logic [dpsc_pkg::COUNT_BITS-1:0]     num_alerts,
  input  logic [dpsc_pkg::DIST_BITS-1:0]      distance_m,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dpsc_pkg::IDX_BITS-1:0]       led_index,
  output logic [dpsc_pkg::CHAN_BITS-1:0]      red,
  output logic [dpsc_pkg::CHAN_BITS-1:0]      green,
  output logic [dpsc_pkg::CHAN_BITS-1:0]      blue,
  output logic                                last_led,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dpsc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [dpsc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import dpsc_pkg::*;

  localparam int B = SINE_TABLE_BITS;
  localparam logic [IDX_BITS-1:0]       LAST_IDX = IDX_BITS'(LED_COUNT - 1);
  localparam logic [B-1:0]              U_STEP   = B'(STEP_U);
  localparam logic [V_BITS:0]           V_STEP   = (V_BITS + 1)'(STEP_V);
  localparam logic [V_BITS:0]           N_EXT    = (V_BITS + 1)'(LED_COUNT);
  localparam logic [DEN_BITS-1:0]       FIVE_H2  = DEN_BITS'(5 * HALF_TURN * HALF_TURN);
  localparam logic [B-1:0]              HALF_B   = B'(HALF_TURN);

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_MOD,
    F_NEG,
    F_DIV,
    F_DONE
  } front_state_t;

  function automatic logic [CHAN_BITS-1:0] scale_chan(input logic [CHAN_BITS-1:0] c,
                                                      input logic [CHAN_BITS-1:0] s);
    logic [2*CHAN_BITS:0] prod;
    prod = (2 * CHAN_BITS + 1)'(c) * ((2 * CHAN_BITS + 1)'(s) + 17'd1);
    return prod[2*CHAN_BITS-1:CHAN_BITS];
  endfunction

  // Configuration registers.
  logic [CHAN_BITS-1:0] color_red;
  logic [CHAN_BITS-1:0] color_green;
  logic [CHAN_BITS-1:0] color_blue;
  logic [DIST_BITS-1:0] max_distance_m;
  logic [CHAN_BITS-1:0] global_brightness;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_red         <= RESET_COLOR_RED;
      color_green       <= RESET_COLOR_GREEN;
      color_blue        <= RESET_COLOR_BLUE;
      max_distance_m    <= RESET_MAX_DISTANCE_M;
      global_brightness <= RESET_GLOBAL_BRIGHTNESS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COLOR_RED:         color_red         <= cfg_data[CHAN_BITS-1:0];
        CFG_COLOR_GREEN:       color_green       <= cfg_data[CHAN_BITS-1:0];
        CFG_COLOR_BLUE:        color_blue        <= cfg_data[CHAN_BITS-1:0];
        CFG_MAX_DISTANCE_M:    max_distance_m    <= cfg_data[DIST_BITS-1:0];
        CFG_GLOBAL_BRIGHTNESS: global_brightness <= cfg_data[CHAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Frame front end.
  front_state_t               fstate;
  logic [TIME_BITS-1:0]       ft;
  logic [K_BITS-1:0]          fk;
  logic [W_BITS-1:0]          fw;
  logic                       fblank;
  logic [PROD_BITS-1:0]       prod;
  logic [W_BITS-1:0]          rem;
  logic [B-1:0]               qr;
  logic [LOOP_CNT_BITS-1:0]   cnt;

  logic [DIST_BITS-1:0] dmax_eff;
  logic [DIST_BITS-1:0] dist_min;
  logic [K_BITS-1:0]    k_in;
  logic [W_BITS-1:0]    w_in;
  logic [W_BITS:0]      mod_shift;
  logic                 mod_take;
  logic [W_BITS:0]      div_shift;
  logic                 div_take;

  logic en;
  logic seq_active;
  logic [IDX_BITS-1:0] seq_i;
  logic seq_free;
  logic seq_load;

  assign in_stall = (fstate != F_IDLE);

  always_comb begin
    dmax_eff  = (max_distance_m == '0) ? DIST_BITS'(1) : max_distance_m;
    dist_min  = (distance_m < dmax_eff) ? distance_m : dmax_eff;
    k_in      = {dmax_eff, 1'b0} - {1'b0, dist_min};
    w_in      = W_BITS'(dmax_eff) * W_BITS'(PHASE_SCALE);
    mod_shift = {rem, prod[PROD_BITS-1]};
    mod_take  = mod_shift >= {1'b0, fw};
    div_shift = {rem, 1'b0};
    div_take  = div_shift >= {1'b0, fw};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
    end else begin
      case (fstate)
        F_IDLE: begin
          if (in_valid && !in_stall) begin
            ft     <= time_ms;
            fk     <= k_in;
            fw     <= w_in;
            fblank <= (num_alerts == '0);
            rem    <= '0;
            fstate <= F_MUL;
          end
        end
        F_MUL: begin
          prod   <= PROD_BITS'(ft) * PROD_BITS'(fk);
          cnt    <= LOOP_CNT_BITS'(PROD_BITS - 1);
          fstate <= F_MOD;
        end
        F_MOD: begin
          rem  <= mod_take ? W_BITS'(mod_shift - {1'b0, fw}) : mod_shift[W_BITS-1:0];
          prod <= prod << 1;
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            fstate <= F_NEG;
          end
        end
        F_NEG: begin
          rem    <= (rem == '0) ? '0 : fw - rem;
          qr     <= '0;
          cnt    <= LOOP_CNT_BITS'(B - 1);
          fstate <= F_DIV;
        end
        F_DIV: begin
          rem <= div_take ? W_BITS'(div_shift - {1'b0, fw}) : div_shift[W_BITS-1:0];
          qr  <= {qr[B-2:0], div_take};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            fstate <= F_DONE;
          end
        end
        F_DONE: begin
          if (seq_free) begin
            fstate <= F_IDLE;
          end
        end
        default: fstate <= F_IDLE;
      endcase
    end
  end

  // LED sequencer.
  logic [B-1:0]        seq_u;
  logic [V_BITS-1:0]   seq_v;
  logic [B-1:0]        f_base;
  logic [CMP_BITS-1:0] f_nrr;
  logic [W_BITS-1:0]   f_w;
  logic                f_blank;
  logic [V_BITS:0]     v_sum;
  logic                v_wrap;
  logic [B-1:0]        u_next;
  logic [V_BITS-1:0]   v_next;

  assign en       = !(out_valid && out_stall);
  assign seq_free = !seq_active || (en && seq_i == LAST_IDX);
  assign seq_load = (fstate == F_DONE) && seq_free;

  always_comb begin
    v_sum  = {1'b0, seq_v} + V_STEP;
    v_wrap = v_sum >= N_EXT;
    v_next = v_wrap ? V_BITS'(v_sum - N_EXT) : v_sum[V_BITS-1:0];
    u_next = seq_u + U_STEP + B'(v_wrap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_active <= 1'b0;
    end else if (seq_load) begin
      seq_active <= 1'b1;
      seq_i      <= '0;
      seq_u      <= '0;
      seq_v      <= '0;
      f_base     <= qr;
      f_nrr      <= CMP_BITS'(LED_COUNT) * CMP_BITS'(rem);
      f_w        <= fw;
      f_blank    <= fblank;
    end else if (en && seq_active) begin
      if (seq_i == LAST_IDX) begin
        seq_active <= 1'b0;
      end
      seq_i <= seq_i + 1'b1;
      seq_u <= u_next;
      seq_v <= v_next;
    end
  end

  // LED pipeline.
  logic                s1_valid;
  led_tag_t            s1_tag;
  logic [B-1:0]        s1_base;
  logic [CMP_BITS-1:0] s1_nrr;
  logic [CMP_BITS-1:0] s1_prod;

  logic                s2_valid;
  led_tag_t            s2_tag;
  logic [B-1:0]        s2_angle;

  logic                dv_valid [0:QUO_BITS];
  led_tag_t            dv_tag   [0:QUO_BITS];
  logic                dv_neg   [0:QUO_BITS];
  logic [NUM_BITS-1:0] dv_rem   [0:QUO_BITS];
  logic [DEN_BITS-1:0] dv_den   [0:QUO_BITS];
  logic [QUO_BITS-1:0] dv_quo   [0:QUO_BITS];
  logic [NUM_BITS-1:0] dv_trial [0:QUO_BITS-1];
  logic                dv_take  [0:QUO_BITS-1];

  logic                lv_valid;
  led_tag_t            lv_tag;
  logic [CHAN_BITS-1:0] lv_level;

  logic                 sc_valid;
  led_tag_t             sc_tag;
  logic [CHAN_BITS-1:0] sc_red;
  logic [CHAN_BITS-1:0] sc_green;
  logic [CHAN_BITS-1:0] sc_blue;

  logic [V_BITS-1:0]    nv;
  logic [B-2:0]         sj;
  logic [B-1:0]         shj;
  logic [Q_BITS-1:0]    sq;
  logic [QUO_BITS:0]    pos_sum;
  logic [QUO_BITS:0]    amp;
  logic [CHAN_BITS-1:0] level;

  always_comb begin
    nv  = V_BITS'(N_EXT) - seq_v;
    sj  = s2_angle[B-2:0];
    shj = HALF_B - {1'b0, sj};
    sq  = Q_BITS'(Q_BITS'(sj) * Q_BITS'(shj));
    for (int k = 0; k < QUO_BITS; k++) begin
      dv_trial[k] = NUM_BITS'(dv_den[k]) << (QUO_BITS - 1 - k);
      dv_take[k]  = dv_rem[k] >= dv_trial[k];
    end
    pos_sum = (QUO_BITS + 1)'(MID_LEVEL) + {1'b0, dv_quo[QUO_BITS]};
    amp     = {1'b0, dv_quo[QUO_BITS]} + (QUO_BITS + 1)'(dv_rem[QUO_BITS] != '0);
    if (dv_neg[QUO_BITS]) begin
      level = (amp >= (QUO_BITS + 1)'(MID_LEVEL)) ? '0
            : CHAN_BITS'((QUO_BITS + 1)'(MID_LEVEL) - amp);
    end else begin
      level = pos_sum[QUO_BITS] ? '1 : pos_sum[CHAN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      for (int k = 0; k <= QUO_BITS; k++) begin
        dv_valid[k] <= 1'b0;
      end
      lv_valid  <= 1'b0;
      sc_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid    <= seq_active;
      s2_valid    <= s1_valid;
      dv_valid[0] <= s2_valid;
      for (int k = 0; k < QUO_BITS; k++) begin
        dv_valid[k+1] <= dv_valid[k];
      end
      lv_valid  <= dv_valid[QUO_BITS];
      sc_valid  <= lv_valid;
      out_valid <= sc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag  <= '{idx: seq_i, last: (seq_i == LAST_IDX), blank: f_blank};
      s1_base <= f_base + seq_u;
      s1_nrr  <= f_nrr;
      s1_prod <= CMP_BITS'(nv) * CMP_BITS'(f_w);

      s2_tag   <= s1_tag;
      s2_angle <= s1_base + B'(s1_nrr >= s1_prod);

      dv_tag[0] <= s2_tag;
      dv_neg[0] <= s2_angle[B-1];
      dv_rem[0] <= {sq, AMP_SHIFT'(0)};
      dv_den[0] <= FIVE_H2 - DEN_BITS'({sq, 2'b00});
      dv_quo[0] <= '0;
      for (int k = 0; k < QUO_BITS; k++) begin
        dv_tag[k+1] <= dv_tag[k];
        dv_neg[k+1] <= dv_neg[k];
        dv_den[k+1] <= dv_den[k];
        dv_rem[k+1] <= dv_take[k] ? dv_rem[k] - dv_trial[k] : dv_rem[k];
        dv_quo[k+1] <= dv_quo[k] | (QUO_BITS'(dv_take[k]) << (QUO_BITS - 1 - k));
      end

      lv_tag   <= dv_tag[QUO_BITS];
      lv_level <= level;

      sc_tag   <= lv_tag;
      sc_red   <= scale_chan(color_red, lv_level);
      sc_green <= scale_chan(color_green, lv_level);
      sc_blue  <= scale_chan(color_blue, lv_level);

      led_index <= sc_tag.idx;
      last_led  <= sc_tag.last;
      red       <= sc_tag.blank ? '0 : scale_chan(sc_red, global_brightness);
      green     <= sc_tag.blank ? '0 : scale_chan(sc_green, global_brightness);
      blue      <= sc_tag.blank ? '0 : scale_chan(sc_blue, global_brightness);
    end
  end

`ifndef SYNTHESIS
  // A frame beat is only taken by an idle front end, which then starts its multiply.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (fstate == F_MUL))
    else $error("front end did not start on an accepted frame beat");

  // The running remainder stays below the phase modulus in both loops.
  assert property (@(posedge clk) disable iff (rst)
    (fstate == F_MOD || fstate == F_DIV) |-> (rem < fw))
    else $error("phase remainder out of range");

  // The sequencer walks the strip one LED per issued beat without skipping.
  assert property (@(posedge clk) disable iff (rst)
    (seq_active && en && seq_i != LAST_IDX) |=>
      (seq_active && seq_i == $past(seq_i) + 1'b1))
    else $error("LED sequencer skipped or stopped early");

  // The end-of-frame flag only marks the final LED.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_led) |-> (led_index == LAST_IDX))
    else $error("last_led on a LED other than the final one");
`endif

endmodule
